### hw/rtl/plane_dedup_hash_table_assert.svh
// Assertion macros used by the plane dedup table checker.
`ifndef PLANE_DEDUP_HASH_TABLE_ASSERT_SVH
`define PLANE_DEDUP_HASH_TABLE_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define PDHT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("plane dedup table assertion failed");

// Antecedent implies consequent in the next cycle.
`define PDHT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("plane dedup table assertion failed");

`endif

### hw/rtl/pdht_pkg.sv
// Shared types, constants and helpers of the plane dedup hash table.
package pdht_pkg;

    localparam int MAX_PLANES   = 4096;
    localparam int HASH_BUCKETS = 8192;
    localparam int IDX_W        = $clog2(MAX_PLANES);
    localparam int BKT_W        = $clog2(HASH_BUCKETS);
    localparam int CNT_W        = IDX_W + 1;

    localparam int NRM_W  = 24;
    localparam int DST_W  = 32;
    localparam int PNT_W  = 32;
    localparam int NTOL_W = 23;
    localparam int DTOL_W = 21;
    localparam int STOL_W = 21;
    localparam int CFG_W  = 23;
    localparam int FRAC_SHIFT = 14;
    localparam int CMP_W  = 34;

    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_FIND  = 2'd1;
    localparam logic [1:0] REQ_SIDE  = 2'd2;

    localparam logic [1:0] PT_ON    = 2'd0;
    localparam logic [1:0] PT_FRONT = 2'd1;
    localparam logic [1:0] PT_BACK  = 2'd2;

    localparam logic [1:0] CFG_NORMAL_TOL = 2'd0;
    localparam logic [1:0] CFG_DIST_TOL   = 2'd1;
    localparam logic [1:0] CFG_SIDE_TOL   = 2'd2;

    localparam logic [NTOL_W-1:0] NTOL_RESET = NTOL_W'(419);
    localparam logic [DTOL_W-1:0] DTOL_RESET = DTOL_W'(328);
    localparam logic [STOL_W-1:0] STOL_RESET = STOL_W'(1638);

    // Bucket head / chain link: valid flag and plane index.
    typedef struct packed {
        logic             vld;
        logic [IDX_W-1:0] idx;
    } t_link;

    typedef struct packed {
        logic signed [NRM_W-1:0] nx;
        logic signed [NRM_W-1:0] ny;
        logic signed [NRM_W-1:0] nz;
        logic signed [DST_W-1:0] dst;
        t_link                   nxt;
    } t_plane;

    localparam int LINK_W  = $bits(t_link);
    localparam int PLANE_W = $bits(t_plane);

    // |a - b| < tol, operands pre-extended so negation and difference never overflow.
    function automatic logic absdiff_lt(input logic signed [CMP_W-1:0] a,
                                        input logic signed [CMP_W-1:0] b,
                                        input logic [NTOL_W-1:0] tol);
        logic signed [CMP_W-1:0] d;
        logic [CMP_W-1:0] m;
        d = a - b;
        m = d[CMP_W-1] ? CMP_W'(-d) : CMP_W'(d);
        return m < {{(CMP_W-NTOL_W){1'b0}}, tol};
    endfunction

endpackage

### hw/rtl/pdht_ram.sv
// Generic simple dual-port RAM with registered read.
module pdht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/plane_dedup_hash_table.sv
// Top level of the plane dedup hash table.
// Plane dedup hash table: stores up to 4096 unique planes (Q2.22 normal, Q18.14 distance)
// in a plane RAM with a chain link per entry, and 8192 bucket heads in a second RAM,
// bucketed on the integer part of |distance| modulo 8192. Every request yields exactly
// one result. A find request reads the heads of buckets hash-1, hash and hash+1 and
// walks each chain newest first; each head read passes through S_HEAD and S_HCHK, each
// compared plane through S_CMP (one read per cycle on the plane RAM port), a miss
// appends in S_INS1 and S_INS2 unless the table is full, and the result is handed off
// in S_DONE. A side query forms the three products of N.P one after another on the
// single shared 24x32 multiplier. A clear request, and reset, sweep all 8192 bucket
// heads one per cycle, and the block accepts no transfer during the sweep; configuration
// writes are taken at any time but must only be made while the block is idle. Accesses
// to one RAM entry never overlap: each read is issued only after the previous write of
// the same request has landed. A finished result waits in the output register while
// the next transfer is accepted.
module plane_dedup_hash_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_req_type,
    input  logic signed [pdht_pkg::NRM_W-1:0] i_normal_x,
    input  logic signed [pdht_pkg::NRM_W-1:0] i_normal_y,
    input  logic signed [pdht_pkg::NRM_W-1:0] i_normal_z,
    input  logic signed [pdht_pkg::DST_W-1:0] i_plane_distance,
    input  logic signed [pdht_pkg::PNT_W-1:0] i_point_x,
    input  logic signed [pdht_pkg::PNT_W-1:0] i_point_y,
    input  logic signed [pdht_pkg::PNT_W-1:0] i_point_z,
    input  logic signed [pdht_pkg::CNT_W-1:0] i_query_index,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [pdht_pkg::IDX_W-1:0]    o_found_index,
    output logic                          o_was_flipped,
    output logic [1:0]                    o_point_side,
    output logic                          o_table_full,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_addr,
    input  logic [pdht_pkg::CFG_W-1:0]    i_cfg_data
);
    import pdht_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_SWEEP = 13'b0000000000010,
        S_HEAD  = 13'b0000000000100,
        S_HCHK  = 13'b0000000001000,
        S_CMP   = 13'b0000000010000,
        S_INS1  = 13'b0000000100000,
        S_INS2  = 13'b0000001000000,
        S_SIDE  = 13'b0000010000000,
        S_SLOAD = 13'b0000100000000,
        S_MUL   = 13'b0001000000000,
        S_MSUM  = 13'b0010000000000,
        S_SCMP  = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } t_state;

    localparam int PROD_W = NRM_W + PNT_W;
    localparam int ACC_W  = PROD_W + 3;
    localparam int SHD_W  = DST_W + 22;

    t_state r_state, n_state;

    // Configuration
    logic [NTOL_W-1:0] r_ntol;
    logic [DTOL_W-1:0] r_dtol;
    logic [STOL_W-1:0] r_stol;

    // Request capture (normals reused for the stored plane of a side query)
    logic signed [NRM_W-1:0] r_nx, n_nx, r_ny, n_ny, r_nz, n_nz;
    logic signed [DST_W-1:0] r_dist, n_dist;
    logic signed [PNT_W-1:0] r_px, n_px, r_py, n_py, r_pz, n_pz;
    logic signed [CNT_W-1:0] r_qidx, n_qidx;

    // Control
    logic [BKT_W-1:0] r_hash, n_hash;
    logic [1:0]       r_k, n_k;
    logic [IDX_W-1:0] r_ptr, n_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic [BKT_W-1:0] r_sweep, n_sweep;
    logic             r_clr_ack, n_clr_ack;
    logic [1:0]       r_mcnt, n_mcnt;

    // Side arithmetic
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic signed [ACC_W-1:0]  r_acc, n_acc;

    // Pending result and output register
    logic [IDX_W-1:0] r_res_idx, n_res_idx;
    logic             r_res_flip, n_res_flip;
    logic [1:0]       r_res_side, n_res_side;
    logic             r_res_full, n_res_full;
    logic             r_out_valid, n_out_valid;
    logic [IDX_W-1:0] r_out_idx, n_out_idx;
    logic             r_out_flip, n_out_flip;
    logic [1:0]       r_out_side, n_out_side;
    logic             r_out_full, n_out_full;

    // RAM ports
    logic             bkt_we;
    logic [BKT_W-1:0] bkt_waddr, bkt_raddr;
    t_link            bkt_wdata, bkt_rdata;
    logic             pl_we;
    logic [IDX_W-1:0] pl_waddr, pl_raddr;
    t_plane           pl_wdata, pl_rdata;

    pdht_ram #(.WIDTH(LINK_W), .DEPTH(HASH_BUCKETS)) u_bucket_ram (
        .i_clk   (i_clk),
        .i_we    (bkt_we),
        .i_waddr (bkt_waddr),
        .i_wdata (bkt_wdata),
        .i_raddr (bkt_raddr),
        .o_rdata (bkt_rdata)
    );

    pdht_ram #(.WIDTH(PLANE_W), .DEPTH(MAX_PLANES)) u_plane_ram (
        .i_clk   (i_clk),
        .i_we    (pl_we),
        .i_waddr (pl_waddr),
        .i_wdata (pl_wdata),
        .i_raddr (pl_raddr),
        .o_rdata (pl_rdata)
    );

    logic [DST_W-1:0]  in_abs;
    logic [BKT_W-1:0]  cur_bkt;
    logic              match_dir, match_neg, hit;
    logic signed [NRM_W-1:0]  mul_a;
    logic signed [PNT_W-1:0]  mul_b;
    logic signed [ACC_W-1:0]  side_t;
    logic              in_xfer, out_free, q_ok;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign in_abs   = i_plane_distance[DST_W-1] ? DST_W'(-i_plane_distance)
                                                : DST_W'(i_plane_distance);
    assign cur_bkt  = r_hash + BKT_W'(r_k) - BKT_W'(1);

    // Compare the stored plane against the request, as given and negated.
    always_comb begin
        logic signed [CMP_W-1:0] sx, sy, sz, sd, gx, gy, gz, gd;
        sx = CMP_W'(pl_rdata.nx);
        sy = CMP_W'(pl_rdata.ny);
        sz = CMP_W'(pl_rdata.nz);
        sd = CMP_W'(pl_rdata.dst);
        gx = CMP_W'(r_nx);
        gy = CMP_W'(r_ny);
        gz = CMP_W'(r_nz);
        gd = CMP_W'(r_dist);
        match_dir = absdiff_lt(sx, gx, r_ntol) && absdiff_lt(sy, gy, r_ntol) &&
                    absdiff_lt(sz, gz, r_ntol) &&
                    absdiff_lt(sd, gd, NTOL_W'(r_dtol));
        match_neg = absdiff_lt(sx, -gx, r_ntol) && absdiff_lt(sy, -gy, r_ntol) &&
                    absdiff_lt(sz, -gz, r_ntol) &&
                    absdiff_lt(sd, -gd, NTOL_W'(r_dtol));
        hit = match_dir || match_neg;
    end

    assign q_ok = !r_qidx[CNT_W-1] && (CNT_W'(r_qidx) < r_count);

    always_comb begin
        case (r_mcnt)
            2'd0: begin
                mul_a = r_nx;
                mul_b = r_px;
            end
            2'd1: begin
                mul_a = r_ny;
                mul_b = r_py;
            end
            default: begin
                mul_a = r_nz;
                mul_b = r_pz;
            end
        endcase
    end

    assign side_t = ACC_W'({r_stol, 22'b0});

    always_comb begin
        n_state    = r_state;
        n_nx = r_nx;  n_ny = r_ny;  n_nz = r_nz;  n_dist = r_dist;
        n_px = r_px;  n_py = r_py;  n_pz = r_pz;  n_qidx = r_qidx;
        n_hash     = r_hash;
        n_k        = r_k;
        n_ptr      = r_ptr;
        n_count    = r_count;
        n_sweep    = r_sweep;
        n_clr_ack  = r_clr_ack;
        n_mcnt     = r_mcnt;
        n_prod     = r_prod;
        n_acc      = r_acc;
        n_res_idx  = r_res_idx;
        n_res_flip = r_res_flip;
        n_res_side = r_res_side;
        n_res_full = r_res_full;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_idx  = r_out_idx;
        n_out_flip = r_out_flip;
        n_out_side = r_out_side;
        n_out_full = r_out_full;

        bkt_we    = 1'b0;
        bkt_waddr = r_sweep;
        bkt_wdata = '0;
        bkt_raddr = cur_bkt;
        pl_we     = 1'b0;
        pl_waddr  = r_count[IDX_W-1:0];
        pl_wdata  = '0;
        pl_raddr  = '0;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_nx = i_normal_x;  n_ny = i_normal_y;  n_nz = i_normal_z;
                    n_dist = i_plane_distance;
                    n_px = i_point_x;  n_py = i_point_y;  n_pz = i_point_z;
                    n_qidx = i_query_index;
                    n_hash = in_abs[FRAC_SHIFT +: BKT_W];
                    n_k = 2'd0;
                    n_res_idx = '0;
                    n_res_flip = 1'b0;
                    n_res_side = PT_ON;
                    n_res_full = 1'b0;
                    case (i_req_type)
                        REQ_CLEAR: begin
                            n_sweep = '0;
                            n_count = '0;
                            n_clr_ack = 1'b1;
                            n_state = S_SWEEP;
                        end
                        REQ_FIND: n_state = S_HEAD;
                        REQ_SIDE: n_state = S_SIDE;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_SWEEP: begin
                // Empty one bucket head per cycle.
                bkt_we = 1'b1;
                n_sweep = r_sweep + BKT_W'(1);
                if (r_sweep == BKT_W'(HASH_BUCKETS - 1)) begin
                    n_state = r_clr_ack ? S_DONE : S_IDLE;
                    n_clr_ack = 1'b0;
                end
            end
            S_HEAD: begin
                // Head read issued at cur_bkt.
                n_state = S_HCHK;
            end
            S_HCHK: begin
                if (bkt_rdata.vld) begin
                    pl_raddr = bkt_rdata.idx;
                    n_ptr = bkt_rdata.idx;
                    n_state = S_CMP;
                end else if (r_k == 2'd2) begin
                    n_state = S_INS1;
                end else begin
                    n_k = r_k + 2'd1;
                    n_state = S_HEAD;
                end
            end
            S_CMP: begin
                if (hit) begin
                    n_res_idx = r_ptr;
                    n_res_flip = !match_dir;
                    n_state = S_DONE;
                end else if (pl_rdata.nxt.vld) begin
                    // Advance along the chain.
                    pl_raddr = pl_rdata.nxt.idx;
                    n_ptr = pl_rdata.nxt.idx;
                end else if (r_k == 2'd2) begin
                    n_state = S_INS1;
                end else begin
                    n_k = r_k + 2'd1;
                    n_state = S_HEAD;
                end
            end
            S_INS1: begin
                bkt_raddr = r_hash;
                if (r_count[IDX_W]) begin
                    n_res_full = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_INS2;
                end
            end
            S_INS2: begin
                // Append plane and link it at the head of its bucket.
                pl_we = 1'b1;
                pl_wdata.nx = r_nx;
                pl_wdata.ny = r_ny;
                pl_wdata.nz = r_nz;
                pl_wdata.dst = r_dist;
                pl_wdata.nxt = bkt_rdata;
                bkt_we = 1'b1;
                bkt_waddr = r_hash;
                bkt_wdata.vld = 1'b1;
                bkt_wdata.idx = r_count[IDX_W-1:0];
                n_res_idx = r_count[IDX_W-1:0];
                n_count = r_count + CNT_W'(1);
                n_state = S_DONE;
            end
            S_SIDE: begin
                if (q_ok) begin
                    pl_raddr = r_qidx[IDX_W-1:0];
                    n_state = S_SLOAD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SLOAD: begin
                n_nx = pl_rdata.nx;
                n_ny = pl_rdata.ny;
                n_nz = pl_rdata.nz;
                n_dist = pl_rdata.dst;
                n_mcnt = 2'd0;
                n_prod = '0;
                n_acc = '0;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_prod = mul_a * mul_b;
                n_acc = r_acc + ACC_W'(r_prod);
                n_mcnt = r_mcnt + 2'd1;
                if (r_mcnt == 2'd2) begin
                    n_state = S_MSUM;
                end
            end
            S_MSUM: begin
                n_acc = r_acc + ACC_W'(r_prod)
                      - ACC_W'($signed(SHD_W'({r_dist, 22'b0})));
                n_state = S_SCMP;
            end
            S_SCMP: begin
                if (r_acc > side_t) begin
                    n_res_side = PT_FRONT;
                end else if (r_acc < -side_t) begin
                    n_res_side = PT_BACK;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                // Hold until the output register is free.
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_idx  = r_res_idx;
                    n_out_flip = r_res_flip;
                    n_out_side = r_res_side;
                    n_out_full = r_res_full;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_sweep     <= '0;
            r_count     <= '0;
            r_clr_ack   <= 1'b0;
            r_k         <= 2'd0;
            r_mcnt      <= 2'd0;
            r_out_valid <= 1'b0;
            r_ntol      <= NTOL_RESET;
            r_dtol      <= DTOL_RESET;
            r_stol      <= STOL_RESET;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_count     <= n_count;
            r_clr_ack   <= n_clr_ack;
            r_k         <= n_k;
            r_mcnt      <= n_mcnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_NORMAL_TOL: r_ntol <= i_cfg_data[NTOL_W-1:0];
                    CFG_DIST_TOL:   r_dtol <= i_cfg_data[DTOL_W-1:0];
                    CFG_SIDE_TOL:   r_stol <= i_cfg_data[STOL_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_nx <= n_nx;  r_ny <= n_ny;  r_nz <= n_nz;  r_dist <= n_dist;
        r_px <= n_px;  r_py <= n_py;  r_pz <= n_pz;  r_qidx <= n_qidx;
        r_hash     <= n_hash;
        r_ptr      <= n_ptr;
        r_prod     <= n_prod;
        r_acc      <= n_acc;
        r_res_idx  <= n_res_idx;
        r_res_flip <= n_res_flip;
        r_res_side <= n_res_side;
        r_res_full <= n_res_full;
        r_out_idx  <= n_out_idx;
        r_out_flip <= n_out_flip;
        r_out_side <= n_out_side;
        r_out_full <= n_out_full;
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_found_index = r_out_idx;
    assign o_was_flipped = r_out_flip;
    assign o_point_side  = r_out_side;
    assign o_table_full  = r_out_full;
endmodule

### hw/rtl/pdht_checker.sv
// Port-level checker of the plane dedup hash table and its bind.
`include "plane_dedup_hash_table_assert.svh"

module pdht_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_in_ready,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic [pdht_pkg::IDX_W-1:0] o_found_index,
    input logic                       o_was_flipped,
    input logic [1:0]                 o_point_side,
    input logic                       o_table_full
);
    import pdht_pkg::*;

    // A result holds until transferred.
    `PDHT_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)
    // A full table reports no index and no flip.
    `PDHT_ASSERT_SAME(a_full_clean, o_out_valid && o_table_full, o_found_index == '0 && !o_was_flipped)
    // Side answers and find answers never mix.
    `PDHT_ASSERT_SAME(a_side_alone, o_out_valid && o_point_side != PT_ON, !o_was_flipped && !o_table_full)
    // The head sweep after reset blocks input.
    `PDHT_ASSERT_SAME(a_sweep_block, $rose(i_rst_n), !o_in_ready)
endmodule

bind plane_dedup_hash_table pdht_checker u_pdht_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_found_index (o_found_index),
    .o_was_flipped (o_was_flipped),
    .o_point_side  (o_point_side),
    .o_table_full  (o_table_full)
);
